// ----- src/lhdd_pkg.sv -----
// Package for the link header descriptor decoder.
// Holds the item structs, type codes, signatures, flag bits and fixed sizes.
// No dependencies.
package lhdd_pkg;

   typedef struct packed {
      logic [7:0] code_first;
      logic [7:0] code_second;
      logic [7:0] byte_three;
      logic [7:0] byte_four;
      logic [7:0] byte_five;
      logic [7:0] byte_six;
      logic [7:0] byte_seven;
      logic [7:0] byte_eight;
      logic [7:0] byte_nine;
   } req_payload_type;

   typedef struct packed {
      logic        status;
      logic [4:0]  flag_bits;
      logic [1:0]  part_total;
      logic [15:0] repeat_last;
      logic [15:0] size_first;
      logic [15:0] size_second;
      logic [15:0] size_third;
   } rsp_payload_type;

   // flag bits
   localparam logic [4:0] FLAG_FINAL   = 5'b00001;
   localparam logic [4:0] FLAG_END     = 5'b00010;
   localparam logic [4:0] FLAG_ALL_END = 5'b00100;
   localparam logic [4:0] FLAG_ALL     = 5'b01000;
   localparam logic [4:0] FLAG_NO_LOG  = 5'b10000;

   // two-character type codes, first character in the high byte
   localparam logic [15:0] CODE_ALL_END = 16'h1717;
   localparam logic [15:0] CODE_END     = 16'h17FF;
   localparam logic [15:0] CODE_A1      = 16'h4131;
   localparam logic [15:0] CODE_AA      = 16'h4141;
   localparam logic [15:0] CODE_AD      = 16'h4144;
   localparam logic [15:0] CODE_AM      = 16'h414D;
   localparam logic [15:0] CODE_DM      = 16'h444D;
   localparam logic [15:0] CODE_SS      = 16'h5353;
   localparam logic [15:0] CODE_SR      = 16'h5352;
   localparam logic [15:0] CODE_AL      = 16'h414C;
   localparam logic [15:0] CODE_BU      = 16'h4255;
   localparam logic [15:0] CODE_DC      = 16'h4443;
   localparam logic [15:0] CODE_DD      = 16'h4444;
   localparam logic [15:0] CODE_EN      = 16'h454E;
   localparam logic [15:0] CODE_EP      = 16'h4550;
   localparam logic [15:0] CODE_F1      = 16'h4631;
   localparam logic [15:0] CODE_F6      = 16'h4636;
   localparam logic [15:0] CODE_G1      = 16'h4731;
   localparam logic [15:0] CODE_P1      = 16'h5031;
   localparam logic [15:0] CODE_FN      = 16'h464E;
   localparam logic [15:0] CODE_FP      = 16'h4650;
   localparam logic [15:0] CODE_GA      = 16'h4741;
   localparam logic [15:0] CODE_GF      = 16'h4746;
   localparam logic [15:0] CODE_GR      = 16'h4752;
   localparam logic [15:0] CODE_GT      = 16'h4754;
   localparam logic [15:0] CODE_RT      = 16'h5254;
   localparam logic [15:0] CODE_M1      = 16'h4D31;
   localparam logic [15:0] CODE_SD      = 16'h5344;
   localparam logic [15:0] CODE_MA      = 16'h4D41;
   localparam logic [15:0] CODE_PD      = 16'h5044;
   localparam logic [15:0] CODE_PZ      = 16'h505A;

   // backup signatures over bytes 3..9, last byte differs
   localparam logic [47:0] BACKUP_SIG_HEAD = 48'h5459_5045_4130; // "TYPEA0"
   localparam logic [7:0]  BACKUP_SIG_A    = 8'h30;              // '0'
   localparam logic [7:0]  BACKUP_SIG_B    = 8'h32;              // '2'
   // screenshot signatures over bytes 5..8
   localparam logic [31:0] COLOR_SIG       = 32'h1155_5746;
   localparam logic [31:0] MONO_SIG        = 32'h1044_5746;

   // fixed part sizes
   localparam logic [15:0] SIZE_BACKUP = 16'd32768;
   localparam logic [15:0] SIZE_PZ     = 16'd190;
   localparam logic [15:0] SIZE_GR     = 16'd92;
   localparam logic [15:0] SIZE_PD3    = 16'd42;
   localparam logic [15:0] SIZE_32     = 16'd32;
   localparam logic [15:0] SIZE_22     = 16'd22;
   localparam logic [15:0] SIZE_14     = 16'd14;

endpackage

// ----- src/link_header_descriptor_decoder.sv -----
// Link header descriptor decoder, top level.
// Depends on lhdd_pkg for the item structs, codes and constants.
//
// Decodes bytes 1 to 9 of a 40-byte link header into a description of the
// data parts that follow: status, flag bits, part count, last-part repeat
// count and up to three part sizes. One request item gives exactly one
// response item. The block is a two-register pipeline: a request register
// and a response register, with the whole decode in between. An accepted
// request is held in the request register, and its response with rsp_valid
// in the response register. One item is taken every cycle as long as the
// response side does not stall. The response register lets one more request
// enter while a finished item waits to be taken. The single 8x8 multiplier
// is shared between the screenshot size (row bytes times height) and the
// matrix repeat count.
module link_header_descriptor_decoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  lhdd_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output lhdd_pkg::rsp_payload_type rsp_data
);
   import lhdd_pkg::*;

   // pipeline registers
   logic            req_valid_ff;
   req_payload_type req_data_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   logic rsp_load;
   logic req_load;

   // response register takes a new item when empty or being drained
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;
   assign req_load  = !req_valid_ff || rsp_load;
   assign req_stall = !req_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_load) begin
            req_valid_ff <= req_valid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_load && req_valid) begin
         req_data_ff <= req_data;
      end
      if (rsp_load && req_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------
   // decode
   // ---------------------------------------------------------------
   logic [15:0] code;
   logic [15:0] word45;
   logic [15:0] word56;
   logic [15:0] word78;
   logic [15:0] word45_gt2;   // field less two, only above two
   logic [15:0] word45_ge2;   // field less two, at two or more
   logic [7:0]  byte6_ge2;
   logic [5:0]  row_bytes;    // screenshot width rounded up to bytes
   logic        is_screen;
   logic [7:0]  mul_a;
   logic [7:0]  mul_b;
   logic [15:0] product;
   logic [15:0] gf_size;
   logic        backup_ok;
   logic        color_ok;
   logic        mono_ok;

   logic [4:0]  flags;
   logic [1:0]  count;
   logic [15:0] rep;
   logic [15:0] s0;
   logic [15:0] s1;
   logic [15:0] s2;

   assign code   = {req_data_ff.code_first, req_data_ff.code_second};
   assign word45 = {req_data_ff.byte_four, req_data_ff.byte_five};
   assign word56 = {req_data_ff.byte_five, req_data_ff.byte_six};
   assign word78 = {req_data_ff.byte_seven, req_data_ff.byte_eight};

   assign word45_gt2 = (word45 > 16'd2)  ? word45 - 16'd2 : word45;
   assign word45_ge2 = (word45 >= 16'd2) ? word45 - 16'd2 : word45;
   assign byte6_ge2  = (req_data_ff.byte_six >= 8'd2) ?
                       req_data_ff.byte_six - 8'd2 : req_data_ff.byte_six;

   assign row_bytes = {1'b0, req_data_ff.byte_three[7:3]}
                    + {5'd0, |req_data_ff.byte_three[2:0]};

   // shared multiplier: row bytes x height for screenshots, else byte5 x byte6
   assign is_screen = (code == CODE_DC) || (code == CODE_DD);
   assign mul_a     = is_screen ? {2'b00, row_bytes} : req_data_ff.byte_five;
   assign mul_b     = is_screen ? req_data_ff.byte_four : req_data_ff.byte_six;
   assign product   = {8'd0, mul_a} * {8'd0, mul_b};

   // 2 + byte6 * 10
   assign gf_size = {5'd0, req_data_ff.byte_six, 3'd0}
                  + {7'd0, req_data_ff.byte_six, 1'b0} + 16'd2;

   assign backup_ok = ({req_data_ff.byte_three, req_data_ff.byte_four,
                        req_data_ff.byte_five, req_data_ff.byte_six,
                        req_data_ff.byte_seven, req_data_ff.byte_eight}
                       == BACKUP_SIG_HEAD)
                   && ((req_data_ff.byte_nine == BACKUP_SIG_A)
                       || (req_data_ff.byte_nine == BACKUP_SIG_B));
   assign color_ok = {req_data_ff.byte_five, req_data_ff.byte_six,
                      req_data_ff.byte_seven, req_data_ff.byte_eight} == COLOR_SIG;
   assign mono_ok  = {req_data_ff.byte_five, req_data_ff.byte_six,
                      req_data_ff.byte_seven, req_data_ff.byte_eight} == MONO_SIG;

   always_comb begin
      flags = '0;
      count = 2'd1;
      rep   = 16'd1;
      s0    = '0;
      s1    = '0;
      s2    = '0;
      unique case (code)
         CODE_ALL_END: begin
            flags = FLAG_ALL_END;
            count = 2'd0;
         end
         CODE_END: begin
            flags = FLAG_END;
            count = 2'd0;
         end
         CODE_A1: begin
            flags = FLAG_FINAL;
            s0    = word45_gt2;
         end
         CODE_AA: begin
            s0 = word45_gt2;
         end
         CODE_AD, CODE_AM, CODE_DM, CODE_SS: begin
            flags = FLAG_FINAL;
            rep   = word56;
            s0    = SIZE_22;
         end
         CODE_SR: begin
            flags = FLAG_FINAL;
            rep   = word56;
            s0    = SIZE_32;
         end
         CODE_AL: begin
            flags = FLAG_ALL;
            count = 2'd0;
         end
         CODE_BU: begin
            flags = FLAG_FINAL;
            if (backup_ok) begin
               s0 = SIZE_BACKUP;
            end
         end
         CODE_DC: begin
            flags = FLAG_FINAL | FLAG_NO_LOG;
            if (color_ok) begin
               rep = 16'd3;
               s0  = product + 16'd1;
            end
         end
         CODE_DD: begin
            flags = FLAG_FINAL | FLAG_NO_LOG;
            if (mono_ok) begin
               s0 = product;
            end
         end
         CODE_EN, CODE_EP, CODE_F1, CODE_F6, CODE_G1, CODE_P1: begin
            flags = FLAG_FINAL;
            s0    = word45_ge2;
         end
         CODE_FN, CODE_FP, CODE_GA: begin
            s0 = word45_ge2;
         end
         CODE_GF: begin
            flags = FLAG_FINAL;
            s0    = gf_size;
         end
         CODE_GR: begin
            flags = FLAG_FINAL;
            s0    = SIZE_GR;
         end
         CODE_GT: begin
            flags = FLAG_FINAL;
            count = 2'd3;
            rep   = word78;
            s0    = {8'd0, byte6_ge2};
            s1    = SIZE_32;
            s2    = SIZE_22;
         end
         CODE_RT: begin
            flags = FLAG_FINAL;
            count = 2'd3;
            rep   = word78;
            s0    = {8'd0, byte6_ge2};
            s1    = SIZE_22;
            s2    = SIZE_32;
         end
         CODE_M1, CODE_SD: begin
            flags = FLAG_FINAL;
            s0    = SIZE_14;
            rep   = product + 16'd1;
         end
         CODE_MA: begin
            s0  = SIZE_14;
            rep = product;
         end
         CODE_PD: begin
            // degree = byte5 * 10 + byte6; small degrees need byte5 zero
            flags = FLAG_FINAL;
            if (req_data_ff.byte_five == 8'd0) begin
               if (req_data_ff.byte_six == 8'd0) begin
                  count = 2'd0;
               end else if (req_data_ff.byte_six == 8'd2) begin
                  s0 = SIZE_32;
               end else if (req_data_ff.byte_six == 8'd3) begin
                  s0 = SIZE_PD3;
               end
            end
         end
         CODE_PZ: begin
            flags = FLAG_FINAL;
            count = 2'd2;
            s0    = SIZE_PZ;
            s1    = word45_ge2;
         end
         default: begin
            // unknown code keeps the defaults and reports an error below
         end
      endcase
   end

   always_comb begin
      rsp_data_in.status      = (count != 2'd0) && (s0 == 16'd0);
      rsp_data_in.flag_bits   = flags;
      rsp_data_in.part_total  = count;
      rsp_data_in.repeat_last = rep;
      rsp_data_in.size_first  = s0;
      rsp_data_in.size_second = s1;
      rsp_data_in.size_third  = s2;
   end

endmodule
